// File: rtl/core/mtu_pkg.sv
// Shared types and codes for the matrix transform unit.
package mtu_pkg;

   localparam logic [1:0] MODE_LOAD_ROW   = 2'd0;
   localparam logic [1:0] MODE_POINT      = 2'd1;
   localparam logic [1:0] MODE_LOAD_RIGHT = 2'd2;
   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam logic [1:0] LAST_ROW        = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         row;
      logic signed [31:0] value0;
      logic signed [31:0] value1;
      logic signed [31:0] value2;
      logic signed [31:0] value3;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res0;
      logic signed [31:0] res1;
      logic signed [31:0] res2;
      logic signed [31:0] res3;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type req;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/mtu_front.sv
// Input side: accepts beats, drops unused modes, queues commands for the back end.
module mtu_front import mtu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   req_type    slot_ff [2];
   logic       accept, keep;

   assign req_full = (count_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign keep     = accept && (req_data.mode != MODE_UNUSED);

   always_comb begin
      count_in = count_ff;
      if (keep && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!keep && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (keep) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

   assign cmd.valid = (count_ff != 2'd0);
   assign cmd.req   = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/mtu_back.sv
// Back end: holds both matrices and runs dot products on one shared multiplier.
module mtu_back import mtu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   state_type          state_ff, state_in;
   logic [1:0]         i_ff, j_ff, k_ff;
   logic               point_ff;
   logic signed [31:0] pt_ff  [4];
   logic signed [31:0] mat_ff [16];
   logic signed [31:0] buf_ff [16];
   logic signed [31:0] res_ff [4];
   logic signed [63:0] prod_ff, acc_ff, acc_sum;
   logic signed [31:0] op_a, op_b, acc_sat;
   logic [1:0]         row_sel;
   logic               emit, out_valid_ff, run_done;
   rsp_type            out_ff;

   assign row_sel  = point_ff ? j_ff : i_ff;
   assign op_a     = mat_ff[{row_sel, k_ff}];
   assign op_b     = point_ff ? pt_ff[k_ff] : buf_ff[{k_ff, j_ff}];
   assign acc_sum  = acc_ff + (prod_ff >>> FRAC_BITS);
   assign acc_sat  = (acc_sum > SAT_MAX) ? 32'sh7fffffff :
                     (acc_sum < SAT_MIN) ? 32'sh80000000 : acc_sum[31:0];
   assign run_done = point_ff ? (j_ff == 2'd2) : (j_ff == LAST_ROW);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.valid && (cmd.req.mode == MODE_POINT ||
                (cmd.req.mode == MODE_LOAD_RIGHT && cmd.req.row == LAST_ROW))) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (k_ff == 2'd3 && run_done) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = (point_ff || i_ff == LAST_ROW) ? ST_IDLE : ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = (state_ff == ST_IDLE) && cmd.valid;
      emit    = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int n = 0; n < 16; n++) begin
            mat_ff[n] <= (n % 5 == 0) ? ONE : 32'sd0;
            buf_ff[n] <= 32'sd0;
         end
      end else begin
         state_ff <= state_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd_pop) begin
            if (cmd.req.mode == MODE_LOAD_ROW) begin
               mat_ff[{cmd.req.row, 2'd0}] <= cmd.req.value0;
               mat_ff[{cmd.req.row, 2'd1}] <= cmd.req.value1;
               mat_ff[{cmd.req.row, 2'd2}] <= cmd.req.value2;
               mat_ff[{cmd.req.row, 2'd3}] <= cmd.req.value3;
            end else if (cmd.req.mode == MODE_LOAD_RIGHT) begin
               buf_ff[{cmd.req.row, 2'd0}] <= cmd.req.value0;
               buf_ff[{cmd.req.row, 2'd1}] <= cmd.req.value1;
               buf_ff[{cmd.req.row, 2'd2}] <= cmd.req.value2;
               buf_ff[{cmd.req.row, 2'd3}] <= cmd.req.value3;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            i_ff     <= 2'd0;
            j_ff     <= 2'd0;
            k_ff     <= 2'd0;
            acc_ff   <= 64'sd0;
            point_ff <= (cmd.req.mode == MODE_POINT);
            pt_ff[0] <= cmd.req.value0;
            pt_ff[1] <= cmd.req.value1;
            pt_ff[2] <= cmd.req.value2;
            pt_ff[3] <= ONE;
            res_ff[3] <= 32'sd0;
         end
         ST_MUL: prod_ff <= op_a * op_b;
         ST_ACC: begin
            k_ff <= k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               res_ff[j_ff] <= acc_sat;
               acc_ff       <= 64'sd0;
               if (!run_done) begin
                  j_ff <= j_ff + 2'd1;
               end
            end else begin
               acc_ff <= acc_sum;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               out_ff.res0 <= res_ff[0];
               out_ff.res1 <= res_ff[1];
               out_ff.res2 <= res_ff[2];
               out_ff.res3 <= res_ff[3];
               out_ff.last <= point_ff || (i_ff == LAST_ROW);
               i_ff        <= i_ff + 2'd1;
               j_ff        <= 2'd0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == ST_IDLE)
      else $error("command taken while busy");
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid_ff)
      else $error("emitted beat lost");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_valid_ff && !rsp_pop) |=> state_ff == ST_EMIT)
      else $error("result overwritten before pop");
   a_acc_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && k_ff == 2'd3 && run_done) |=> state_ff == ST_EMIT)
      else $error("row finished without emit");
`endif

endmodule

// File: rtl/core/matrix4_transform_unit.sv
// Top level of the 4x4 fixed-point matrix transform unit.
//
//   channel   ports                        direction
//   request   req_push req_full req_data   in, queue push side
//   response  rsp_pop rsp_empty rsp_data   out, queue pop side
//
// Loads of a stored or right-hand row are written when the idle back end takes them.
// A point runs 12 products, each a multiply then an accumulate step, plus emit.
// A matrix product after right row 3 runs on the one shared multiplier.
// Reset is synchronous; it restores the identity matrix and clears the right buffer.
// A two-entry command queue lets requests arrive while the back end is busy or stalled.
module matrix4_transform_unit import mtu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cmd_type cmd;
   logic    cmd_pop;

   mtu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   mtu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb.sv
// Testbench for the matrix transform unit: queue-fed driver, monitor and row-level predictor.
`timescale 1ns / 100ps

module tb;
   import mtu_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   req_type     pending_reqs[$];
   rsp_type     expected_rows[$];
   logic signed [31:0] stored_matrix[16];
   logic signed [31:0] right_matrix[16];
   int          error_count;
   int          gap_left;
   int          stall_left;

   localparam int FRAC = 16;

   matrix4_transform_unit u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // product shifted by FRAC, floor toward minus infinity
   function automatic logic signed [63:0] fx_product(logic signed [31:0] a,
                                                    logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> FRAC;
   endfunction

   function automatic logic signed [31:0] sat_dot(
         logic signed [31:0] a0, logic signed [31:0] a1,
         logic signed [31:0] a2, logic signed [31:0] a3,
         logic signed [31:0] b0, logic signed [31:0] b1,
         logic signed [31:0] b2, logic signed [31:0] b3);
      logic signed [65:0] s;
      s = 66'(fx_product(a0, b0)) + 66'(fx_product(a1, b1))
        + 66'(fx_product(a2, b2)) + 66'(fx_product(a3, b3));
      if (s > 66'sd2147483647) return 32'sh7fffffff;
      if (s < -66'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   task automatic apply_request(req_type r);
      logic signed [31:0] v[4];
      rsp_type o;
      v[0] = r.value0; v[1] = r.value1; v[2] = r.value2; v[3] = r.value3;
      case (r.mode)
         MODE_LOAD_ROW: begin
            for (int i = 0; i < 4; i++) stored_matrix[r.row*4+i] = v[i];
         end
         MODE_POINT: begin
            o.res0 = sat_dot(stored_matrix[0], stored_matrix[1], stored_matrix[2],
                             stored_matrix[3], v[0], v[1], v[2], 32'sd65536);
            o.res1 = sat_dot(stored_matrix[4], stored_matrix[5], stored_matrix[6],
                             stored_matrix[7], v[0], v[1], v[2], 32'sd65536);
            o.res2 = sat_dot(stored_matrix[8], stored_matrix[9], stored_matrix[10],
                             stored_matrix[11], v[0], v[1], v[2], 32'sd65536);
            o.res3 = '0;
            o.last = 1'b1;
            expected_rows.push_back(o);
         end
         MODE_LOAD_RIGHT: begin
            logic signed [31:0] e[4];
            for (int i = 0; i < 4; i++) right_matrix[r.row*4+i] = v[i];
            if (r.row == LAST_ROW) begin
               for (int i = 0; i < 4; i++) begin
                  for (int j = 0; j < 4; j++)
                     e[j] = sat_dot(stored_matrix[i*4], stored_matrix[i*4+1],
                                    stored_matrix[i*4+2], stored_matrix[i*4+3],
                                    right_matrix[j], right_matrix[4+j],
                                    right_matrix[8+j], right_matrix[12+j]);
                  o.res0 = e[0]; o.res1 = e[1]; o.res2 = e[2]; o.res3 = e[3];
                  o.last = (i == 3);
                  expected_rows.push_back(o);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00010000 * $urandom_range(0, 4);
         3: return -(32'h00010000 * $urandom_range(1, 4));
         4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] m, logic [1:0] r);
      req_type q;
      q.mode = m; q.row = r;
      q.value0 = rand_value(); q.value1 = rand_value();
      q.value2 = rand_value(); q.value3 = rand_value();
      return q;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // driver: hold each beat until taken, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (req_push && !req_full) begin
         int g;
         void'(pending_reqs.pop_front());
         g = pick_gap();
         gap_left <= g;
         if (g == 0 && pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end else if (!req_push) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            req_push <= 1'b1;
         end
      end
   end

   // predict on acceptance, in input order
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) apply_request(req_data);
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data.res0, 32'h0);
            end else begin
               rsp_type w;
               w = expected_rows.pop_front();
               if (rsp_data.res0 !== w.res0) report_mismatch("res0", rsp_data.res0, w.res0);
               if (rsp_data.res1 !== w.res1) report_mismatch("res1", rsp_data.res1, w.res1);
               if (rsp_data.res2 !== w.res2) report_mismatch("res2", rsp_data.res2, w.res2);
               if (rsp_data.res3 !== w.res3) report_mismatch("res3", rsp_data.res3, w.res3);
               if (rsp_data.last !== w.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(w.last));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            stall_left <= pick_gap();
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      req_type q;
      error_count = 0;
      reset = 1'b1;
      for (int i = 0; i < 16; i++) begin
         stored_matrix[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
         right_matrix[i] = '0;
      end
      // directed: identity point, unused mode, product with identity, extremes
      q = '0; q.mode = MODE_POINT;
      q.value0 = 32'sh7fffffff; q.value1 = 32'sh80000000; q.value2 = 32'sd65536;
      pending_reqs.push_back(q);
      q = make_req(MODE_UNUSED, 2'd1); pending_reqs.push_back(q);
      q = make_req(MODE_LOAD_RIGHT, LAST_ROW); pending_reqs.push_back(q);
      for (int r = 0; r < 4; r++) begin
         q = '0; q.mode = MODE_LOAD_ROW; q.row = 2'(r);
         q.value0 = 32'sh7fffffff; q.value1 = 32'sh7fffffff;
         q.value2 = 32'sh80000000; q.value3 = 32'shffffffff;
         pending_reqs.push_back(q);
      end
      q = '0; q.mode = MODE_POINT;
      q.value0 = 32'sh7fffffff; q.value1 = 32'sh7fffffff; q.value2 = 32'sh80000000;
      q.value3 = 32'shffffffff;
      pending_reqs.push_back(q);
      for (int r = 0; r < 4; r++) begin
         q = '0; q.mode = MODE_LOAD_RIGHT; q.row = 2'(r);
         q.value0 = 32'sh80000000; q.value1 = 32'sh7fffffff;
         q.value2 = 32'sh80000000; q.value3 = 32'sh00000001;
         pending_reqs.push_back(q);
      end
      // random: mostly full right-matrix sequences, points and row loads
      while (pending_reqs.size() < 420) begin
         case ($urandom_range(0, 5))
            0, 1: for (int r = 0; r < 4; r++)
                     pending_reqs.push_back(make_req(MODE_LOAD_RIGHT, 2'(r)));
            2: pending_reqs.push_back(make_req(MODE_POINT, 2'($urandom_range(0, 3))));
            3: pending_reqs.push_back(make_req(MODE_LOAD_ROW, 2'($urandom_range(0, 3))));
            default: pending_reqs.push_back(make_req(2'($urandom_range(0, 3)),
                                                      2'($urandom_range(0, 3))));
         endcase
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0);
      // let the predictor take the last beat first
      @(posedge clock);
      wait (expected_rows.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
